// ===== design/pcacc_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid accumulator package
// Shared widths, payload structs and the back-end state type.
// ----------------------------------------------------------------------------
package pcacc_pkg;

   localparam int COORD_BITS    = 16;
   localparam int PROD_BITS     = 2 * COORD_BITS;
   localparam int PSUM_BITS     = COORD_BITS + 1;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int TERM_BITS     = CROSS_BITS + PSUM_BITS;
   localparam int AREA_BITS     = 41;
   localparam int WSUM_BITS     = 58;
   localparam int QUOT_BITS     = COORD_BITS + 1;
   localparam int NUM_BITS      = WSUM_BITS + 2;
   localparam int DEN_BITS      = AREA_BITS + 3;
   localparam int DSR_BITS      = DEN_BITS + QUOT_BITS;
   localparam int CNT_BITS      = $clog2(QUOT_BITS + 1);
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [QUOT_BITS-1:0] QUOT_LIM = QUOT_BITS'(1) << (COORD_BITS - 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic                         last_edge;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] centroid_x;
      logic signed [COORD_BITS-1:0] centroid_y;
      logic                         degenerate;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic [PROD_BITS-1:0] prod_a;
      logic [PROD_BITS-1:0] prod_b;
      logic [PSUM_BITS-1:0] sum_x;
      logic [PSUM_BITS-1:0] sum_y;
      logic                 last;
   } prod_type;

   typedef struct packed {
      logic                 busy;
      logic                 over;
      logic [QUOT_BITS-1:0] quot;
   } div_status_type;

   typedef enum logic [2:0] {
      BK_RUN,
      BK_ABS,
      BK_LOAD,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage

// ===== design/polygon_centroid_accumulator.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid accumulator
// Shoelace centroid of a polygon that arrives one edge per beat.
// Throughput: one edge per cycle while the back end is accumulating.
// After the last edge of a polygon the back end runs its restoring dividers;
// it takes no further edge meanwhile, but the front end and the four-beat
// queue keep accepting until the queue is full.
// Reset is synchronous and clears all sums, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module polygon_centroid_accumulator import pcacc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     push_valid, push_stall;
   prod_type push_data;
   logic     pop_valid, pop_stall;
   prod_type pop_data;

   pcacc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data)
   );

   pcacc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_data   (pop_data)
   );

   pcacc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_stall (pop_stall),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/pcacc_front.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid front end
// Accepts edges and forms the two products of the cross term and the coordinate sums.
// ----------------------------------------------------------------------------
module pcacc_front import pcacc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_stall,
   output prod_type push_data
);

   logic     stage_valid_ff, stage_valid_in;
   prod_type stage_ff, stage_in;
   logic     accept;

   assign req_stall  = stage_valid_ff && push_stall;
   assign accept     = req_valid && !req_stall;
   assign push_valid = stage_valid_ff;
   assign push_data  = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.prod_a = PROD_BITS'(req_data.start_x * req_data.end_y);
         stage_in.prod_b = PROD_BITS'(req_data.end_x * req_data.start_y);
         stage_in.sum_x  = {req_data.start_x[COORD_BITS-1], req_data.start_x}
                         + {req_data.end_x[COORD_BITS-1], req_data.end_x};
         stage_in.sum_y  = {req_data.start_y[COORD_BITS-1], req_data.start_y}
                         + {req_data.end_y[COORD_BITS-1], req_data.end_y};
         stage_in.last   = req_data.last_edge;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_valid_ff && !push_stall) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

// ===== design/pcacc_fifo.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid edge queue
// Short queue of product beats between the front end and the back end.
// ----------------------------------------------------------------------------
module pcacc_fifo import pcacc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_stall,
   input  prod_type push_data,
   output logic     pop_valid,
   input  logic     pop_stall,
   output prod_type pop_data
);

   prod_type                 slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     push, pop;

   assign push_stall = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fifo_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("Edge queue holds more beats than it has slots.");

endmodule

// ===== design/pcacc_div.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid divider
// Restoring divider, one quotient bit per cycle, with an overflow check.
// ----------------------------------------------------------------------------
module pcacc_div import pcacc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output div_status_type      status
);

   logic                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]  rem_ff, rem_in;
   logic [DSR_BITS-1:0]  dsr_ff, dsr_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic                 over_ff, over_in;
   logic                 ge;

   assign ge = ({1'b0, rem_ff} >= dsr_ff);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      over_in = over_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QUOT_BITS);
         rem_in  = num;
         dsr_in  = {den, {QUOT_BITS{1'b0}}};
         quot_in = '0;
         over_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_BITS'(QUOT_BITS)) begin
            over_in = ge;
         end else begin
            if (ge) begin
               rem_in = rem_ff - dsr_ff[NUM_BITS-1:0];
            end
            quot_in = {quot_ff[QUOT_BITS-2:0], ge};
         end
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      over_ff <= over_in;
   end

   assign status.busy = busy_ff;
   assign status.over = over_ff;
   assign status.quot = quot_ff;

endmodule

// ===== design/pcacc_back.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid back end
// Accumulates the shoelace sums and, on the last edge, divides and rounds.
// ----------------------------------------------------------------------------
module pcacc_back import pcacc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_stall,
   input  prod_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   back_state_type state_ff, state_in;

   logic                  term_valid_ff, term_valid_in;
   logic                  term_last_ff;
   logic [CROSS_BITS-1:0] cross_ff, cross_in;
   logic [TERM_BITS-1:0]  tx_ff;
   logic [TERM_BITS-1:0]  ty_ff;

   logic [AREA_BITS-1:0]  area_ff, area_in;
   logic [WSUM_BITS-1:0]  wx_ff, wx_in;
   logic [WSUM_BITS-1:0]  wy_ff, wy_in;

   logic [AREA_BITS-1:0]  abs_a_ff;
   logic [WSUM_BITS-1:0]  abs_x_ff, abs_y_ff;
   logic                  sgn_x_ff, sgn_y_ff, zero_ff;

   logic [AREA_BITS+1:0]  a3;
   logic [NUM_BITS-1:0]   num_x, num_y;
   logic [DEN_BITS-1:0]   den;
   div_status_type        st_x, st_y;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [COORD_BITS:0]   res_x, res_y;

   logic term_go, div_start, out_try, out_free, term_fire, term_load;

   function automatic logic [COORD_BITS:0] clip_coord(input logic [QUOT_BITS-1:0] q,
                                                      input logic over,
                                                      input logic sgn);
      logic                  neg;
      logic                  clip;
      logic [COORD_BITS-1:0] v;
      neg  = sgn && (over || (q != '0));
      clip = 1'b0;
      if (neg) begin
         if (over || (q > QUOT_LIM)) begin
            clip = 1'b1;
            v    = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            v = COORD_BITS'(~q + 1'b1);
         end
      end else begin
         if (over || (q > QUOT_LIM - 1'b1)) begin
            clip = 1'b1;
            v    = {1'b0, {(COORD_BITS-1){1'b1}}};
         end else begin
            v = q[COORD_BITS-1:0];
         end
      end
      return {clip, v};
   endfunction

   // State decoding.
   always_comb begin
      term_go   = (state_ff == BK_RUN);
      div_start = (state_ff == BK_LOAD);
      out_try   = (state_ff == BK_OUT);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign term_fire = term_valid_ff && term_go;
   assign term_load = pop_valid && (!term_valid_ff || term_fire);
   assign pop_stall = !(!term_valid_ff || term_fire);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (term_fire && term_last_ff) begin
               state_in = BK_ABS;
            end
         end
         BK_ABS: begin
            state_in = (area_ff == '0) ? BK_OUT : BK_LOAD;
         end
         BK_LOAD: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (!st_x.busy && !st_y.busy) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // Term stage: cross term and the two weighted terms.
   always_comb begin
      cross_in = {pop_data.prod_a[PROD_BITS-1], pop_data.prod_a}
               - {pop_data.prod_b[PROD_BITS-1], pop_data.prod_b};
      term_valid_in = term_valid_ff;
      if (term_load) begin
         term_valid_in = 1'b1;
      end else if (term_fire) begin
         term_valid_in = 1'b0;
      end
   end

   logic [TERM_BITS-1:0] wx_term, wy_term;
   always_comb begin
      wx_term = $signed({{CROSS_BITS{pop_data.sum_x[PSUM_BITS-1]}}, pop_data.sum_x})
              * $signed({{PSUM_BITS{cross_in[CROSS_BITS-1]}}, cross_in});
      wy_term = $signed({{CROSS_BITS{pop_data.sum_y[PSUM_BITS-1]}}, pop_data.sum_y})
              * $signed({{PSUM_BITS{cross_in[CROSS_BITS-1]}}, cross_in});
   end

   // Accumulation and clearing of the sums.
   always_comb begin
      area_in = area_ff;
      wx_in   = wx_ff;
      wy_in   = wy_ff;
      if (term_fire) begin
         area_in = area_ff + {{(AREA_BITS-CROSS_BITS){cross_ff[CROSS_BITS-1]}}, cross_ff};
         wx_in   = wx_ff + {{(WSUM_BITS-TERM_BITS){tx_ff[TERM_BITS-1]}}, tx_ff};
         wy_in   = wy_ff + {{(WSUM_BITS-TERM_BITS){ty_ff[TERM_BITS-1]}}, ty_ff};
      end else if (state_ff == BK_ABS) begin
         area_in = '0;
         wx_in   = '0;
         wy_in   = '0;
      end
   end

   // Divider operands: numerator 2|w| + 3|a|, denominator 6|a|.
   always_comb begin
      a3    = {2'b00, abs_a_ff} + {1'b0, abs_a_ff, 1'b0};
      num_x = {1'b0, abs_x_ff, 1'b0} + NUM_BITS'(a3);
      num_y = {1'b0, abs_y_ff, 1'b0} + NUM_BITS'(a3);
      den   = {a3, 1'b0};
   end

   pcacc_div u_div_x (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_x),
      .den    (den),
      .status (st_x)
   );

   pcacc_div u_div_y (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_y),
      .den    (den),
      .status (st_y)
   );

   always_comb begin
      res_x        = clip_coord(st_x.quot, st_x.over, sgn_x_ff);
      res_y        = clip_coord(st_y.quot, st_y.over, sgn_y_ff);
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_try && out_free) begin
         rsp_valid_in = 1'b1;
         if (zero_ff) begin
            rsp_in.centroid_x = '0;
            rsp_in.centroid_y = '0;
            rsp_in.degenerate = 1'b1;
            rsp_in.saturated  = 1'b0;
         end else begin
            rsp_in.centroid_x = res_x[COORD_BITS-1:0];
            rsp_in.centroid_y = res_y[COORD_BITS-1:0];
            rsp_in.degenerate = 1'b0;
            rsp_in.saturated  = res_x[COORD_BITS] | res_y[COORD_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         term_valid_ff <= 1'b0;
         area_ff       <= '0;
         wx_ff         <= '0;
         wy_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         term_valid_ff <= term_valid_in;
         area_ff       <= area_in;
         wx_ff         <= wx_in;
         wy_ff         <= wy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (term_load) begin
         cross_ff     <= cross_in;
         tx_ff        <= wx_term;
         ty_ff        <= wy_term;
         term_last_ff <= pop_data.last;
      end
      if (state_ff == BK_ABS) begin
         abs_a_ff <= area_ff[AREA_BITS-1] ? (~area_ff + 1'b1) : area_ff;
         abs_x_ff <= wx_ff[WSUM_BITS-1] ? (~wx_ff + 1'b1) : wx_ff;
         abs_y_ff <= wy_ff[WSUM_BITS-1] ? (~wy_ff + 1'b1) : wy_ff;
         sgn_x_ff <= wx_ff[WSUM_BITS-1] ^ area_ff[AREA_BITS-1];
         sgn_y_ff <= wy_ff[WSUM_BITS-1] ^ area_ff[AREA_BITS-1];
         zero_ff  <= (area_ff == '0);
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      st_x.busy == st_y.busy)
      else $error("The two dividers are out of step.");

   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LOAD) |=> (st_x.busy && st_y.busy))
      else $error("Dividers did not start after operand load.");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ABS) |=> (area_ff == '0 && wx_ff == '0 && wy_ff == '0))
      else $error("Sums were not cleared after the last edge.");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Polygon centroid accumulator testbench
// Sends polygons one edge per beat: closed shapes at random scales and
// offsets, broken and noisy edge runs, and a long run that wraps the sums.
// Each centroid that comes back is checked against an in-bench shoelace
// predictor. The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
   import pcacc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic    drain_first;
      req_type seg;
   } edge_slot_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    req_taken = 1'b0;

   edge_slot_type pending_edges[$];
   rsp_type       centroid_due[$];

   logic signed [AREA_BITS-1:0] area_acc = '0;
   logic signed [WSUM_BITS-1:0] xmom_acc = '0;
   logic signed [WSUM_BITS-1:0] ymom_acc = '0;

   int errors = 0;
   int edges_sent = 0;
   int centroids_seen = 0;
   int degenerate_seen = 0;
   int clipped_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int free_left = 0;

   polygon_centroid_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Rounded quotient num / (3 * den), clipped to the coordinate range.
   // The top bit of the return value tells whether clipping took place.
   function automatic logic [COORD_BITS:0] centroid_div(input longint num, input longint den);
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      longint unsigned lim;
      logic            neg;
      logic            clip;
      n = (num < 0) ? longint'(-num) : num;
      d = 64'd3 * ((den < 0) ? longint'(-den) : den);
      q = (64'd2 * n + d) / (64'd2 * d);
      neg = ((num < 0) != (den < 0)) && (q != 0);
      lim = 64'd1 << (COORD_BITS - 1);
      clip = 1'b0;
      if (neg) begin
         if (q > lim) begin
            q = lim;
            clip = 1'b1;
         end
         q = -q;
      end else if (q > lim - 1) begin
         q = lim - 1;
         clip = 1'b1;
      end
      return {clip, q[COORD_BITS-1:0]};
   endfunction

   // Adds one edge to the running shoelace sums; returns 1 with the centroid
   // when the edge closes the polygon.
   function automatic logic shoelace_step(input req_type seg, output rsp_type res);
      longint              sx;
      longint              sy;
      longint              ex;
      longint              ey;
      longint              cross_term;
      longint              area;
      logic [COORD_BITS:0] cx;
      logic [COORD_BITS:0] cy;
      sx = $signed(seg.start_x);
      sy = $signed(seg.start_y);
      ex = $signed(seg.end_x);
      ey = $signed(seg.end_y);
      cross_term = sx * ey - ex * sy;
      area_acc = AREA_BITS'(area_acc + cross_term);
      xmom_acc = WSUM_BITS'(xmom_acc + (sx + ex) * cross_term);
      ymom_acc = WSUM_BITS'(ymom_acc + (sy + ey) * cross_term);
      res = '0;
      if (!seg.last_edge) begin
         return 1'b0;
      end
      area = longint'(area_acc);
      if (area == 0) begin
         res.degenerate = 1'b1;
      end else begin
         cx = centroid_div(longint'(xmom_acc), area);
         cy = centroid_div(longint'(ymom_acc), area);
         res.centroid_x = cx[COORD_BITS-1:0];
         res.centroid_y = cy[COORD_BITS-1:0];
         res.saturated = cx[COORD_BITS] | cy[COORD_BITS];
      end
      area_acc = '0;
      xmom_acc = '0;
      ymom_acc = '0;
      return 1'b1;
   endfunction

   function automatic void queue_edge(int sx, int sy, int ex, int ey, bit last, bit drain);
      edge_slot_type slot;
      slot.drain_first = drain;
      slot.seg.start_x = COORD_BITS'(sx);
      slot.seg.start_y = COORD_BITS'(sy);
      slot.seg.end_x = COORD_BITS'(ex);
      slot.seg.end_y = COORD_BITS'(ey);
      slot.seg.last_edge = last;
      pending_edges.push_back(slot);
   endfunction

   // A closed polygon at a random scale and offset; a broken one drops an edge.
   function automatic int queue_polygon(int n, bit broken, bit drain);
      logic signed [COORD_BITS-1:0] vx[16];
      logic signed [COORD_BITS-1:0] vy[16];
      logic signed [COORD_BITS-1:0] ox;
      logic signed [COORD_BITS-1:0] oy;
      int shift;
      int skip;
      int last_idx;
      int count;
      shift = $urandom_range(15);
      ox = COORD_BITS'($urandom);
      oy = COORD_BITS'($urandom);
      ox = ox >>> $urandom_range(15);
      oy = oy >>> $urandom_range(15);
      for (int i = 0; i < n; i++) begin
         vx[i] = COORD_BITS'($urandom);
         vy[i] = COORD_BITS'($urandom);
         vx[i] = (vx[i] >>> shift) + ox;
         vy[i] = (vy[i] >>> shift) + oy;
      end
      skip = broken ? $urandom_range(n - 1) : -1;
      last_idx = (skip == n - 1) ? n - 2 : n - 1;
      count = 0;
      for (int i = 0; i < n; i++) begin
         if (i != skip) begin
            queue_edge(int'(vx[i]), int'(vy[i]), int'(vx[(i + 1) % n]),
                       int'(vy[(i + 1) % n]), i == last_idx, drain && count == 0);
            count++;
         end
      end
      return count;
   endfunction

   function automatic int queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         queue_edge($urandom, $urandom, $urandom, $urandom,
                    (i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(3) == 0), 1'b0);
      end
      return n;
   endfunction

   // Sender: presents the head of the queue in bursts with gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_edges.size() != 0 &&
                      !(pending_edges[0].drain_first && centroid_due.size() != 0)) begin
            req_valid <= 1'b1;
            req_data <= pending_edges[0].seg;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 50)
                                                     : $urandom_range(1, 20);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls in short runs, with long quiet stretches now and then.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (free_left > 0) begin
            free_left--;
         end else if ($urandom_range(9) == 0) begin
            free_left = $urandom_range(200, 60);
         end else begin
            stall_left = $urandom_range(6);
            free_left = $urandom_range(4);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            edges_sent++;
            if (shoelace_step(req_data, want)) begin
               centroid_due.push_back(want);
            end
            void'(pending_edges.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            got = rsp_data;
            centroids_seen++;
            degenerate_seen += got.degenerate;
            clipped_seen += got.saturated;
            if (centroid_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("Unexpected result beat: x=%0d y=%0d degenerate=%0b saturated=%0b",
                           got.centroid_x, got.centroid_y, got.degenerate, got.saturated);
               end
            end else begin
               want = centroid_due.pop_front();
               if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
                   got.degenerate !== want.degenerate || got.saturated !== want.saturated) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("Centroid mismatch: expected x=%0d y=%0d deg=%0b sat=%0b",
                              want.centroid_x, want.centroid_y, want.degenerate,
                              want.saturated);
                     $display("                   actual   x=%0d y=%0d deg=%0b sat=%0b",
                              got.centroid_x, got.centroid_y, got.degenerate, got.saturated);
                  end
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      int pick;

      // Zero-length edge closing at once: degenerate.
      queue_edge(0, 0, 0, 0, 1'b1, 1'b0);
      // A triangle in both orientations.
      queue_edge(0, 0, 160, 0, 1'b0, 1'b0);
      queue_edge(160, 0, 0, 160, 1'b0, 1'b0);
      queue_edge(0, 160, 0, 0, 1'b1, 1'b0);
      queue_edge(0, 0, 0, 160, 1'b0, 1'b1);
      queue_edge(0, 160, 160, 0, 1'b0, 1'b0);
      queue_edge(160, 0, 0, 0, 1'b1, 1'b0);
      // Tiny area with large moments: clips high in x, then low in x.
      queue_edge(32767, 1, 32767, 2, 1'b0, 1'b0);
      queue_edge(0, 1, 32766, 0, 1'b1, 1'b0);
      queue_edge(-32767, 1, -32767, 2, 1'b0, 1'b0);
      queue_edge(0, 1, -32766, 0, 1'b1, 1'b0);
      // The first of these again in y: clips high in y.
      queue_edge(1, 32767, 2, 32767, 1'b0, 1'b0);
      queue_edge(1, 0, 0, 32766, 1'b1, 1'b0);
      // Full-range square; its centroid sits on a rounding tie.
      queue_edge(-32768, -32768, 32767, -32768, 1'b0, 1'b1);
      queue_edge(32767, -32768, 32767, 32767, 1'b0, 1'b0);
      queue_edge(32767, 32767, -32768, 32767, 1'b0, 1'b0);
      queue_edge(-32768, 32767, -32768, -32768, 1'b1, 1'b0);
      // An edge and its reverse cancel: degenerate.
      queue_edge(5, 7, 100, 3, 1'b0, 1'b0);
      queue_edge(100, 3, 5, 7, 1'b1, 1'b0);

      sent = 0;
      while (sent < 360) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            sent += queue_polygon($urandom_range(3, 12), 1'b0, $urandom_range(39) == 0);
         end else if (pick < 85) begin
            sent += queue_polygon($urandom_range(3, 12), 1'b1, 1'b0);
         end else begin
            sent += queue_noise();
         end
      end

      // Enough maximal cross terms to wrap the area sum.
      for (int i = 0; i < 520; i++) begin
         queue_edge(32767, 32767, -32768, 32767, i == 519, i == 0);
      end

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      while (pending_edges.size() != 0 || centroid_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d edges; checked %0d centroids, %0d degenerate and %0d clipped.",
               edges_sent, centroids_seen, degenerate_seen, clipped_seen);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d errors found.", errors);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/pcacc_pkg.sv
design/pcacc_front.sv
design/pcacc_fifo.sv
design/pcacc_div.sv
design/pcacc_back.sv
design/polygon_centroid_accumulator.sv
tb/testbench.sv
